>>> hdl/emr_pkg.sv
// ----------------------------------------------------------------------------
// emr_pkg
// Types, constants and helpers for the Eller maze row generator.
// ----------------------------------------------------------------------------
package emr_pkg;

  localparam int MaxCols = 16;
  localparam int ColW    = $clog2(MaxCols);
  localparam int NumW    = ColW + 1;
  localparam int RowW    = 16;
  localparam int CfgW    = 16;

  typedef enum logic {
    CfgColsInUse = 1'b0,
    CfgRowsInUse = 1'b1
  } emr_cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StMerge,
    StGroup,
    StWait,
    StFresh,
    StEmit
  } emr_state_e;

  typedef struct packed {
    logic [14:0] merge_bits;
    logic [15:0] extra_down_bits;
    logic [63:0] pick_word;
  } emr_item_t;

  typedef struct packed {
    logic [ColW-1:0] cell_column;
    logic [RowW-1:0] cell_row;
    logic            open_north;
    logic            open_south;
    logic            open_east;
    logic            open_west;
    logic            last_in_row;
  } emr_word_t;

  typedef struct packed {
    logic            start;
    logic [3:0]      dividend;
    logic [NumW-1:0] divisor;
  } emr_mod_req_t;

  typedef struct packed {
    logic       done;
    logic [3:0] rem;
  } emr_mod_rsp_t;

  function automatic logic [NumW-1:0] popcount(input logic [MaxCols-1:0] v);
    logic [NumW-1:0] s;
    s = '0;
    for (int i = 0; i < MaxCols; i++) begin
      s = s + NumW'(v[i]);
    end
    return s;
  endfunction

endpackage

>>> hdl/emr_if.sv
// ----------------------------------------------------------------------------
// emr_in_if / emr_out_if
// Valid/ready channels for row items and cell words.
// ----------------------------------------------------------------------------
interface emr_in_if;
  logic                valid;
  logic                ready;
  logic [14:0]         merge_bits;
  logic [15:0]         extra_down_bits;
  logic [63:0]         pick_word;

  modport source (output valid, merge_bits, extra_down_bits, pick_word, input ready);
  modport sink   (input valid, merge_bits, extra_down_bits, pick_word, output ready);
endinterface

interface emr_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cell_column;
  logic [15:0] cell_row;
  logic        open_north;
  logic        open_south;
  logic        open_east;
  logic        open_west;
  logic        last_in_row;

  modport source (output valid, cell_column, cell_row, open_north, open_south, open_east,
                  open_west, last_in_row, input ready);
  modport sink   (input valid, cell_column, cell_row, open_north, open_south, open_east,
                  open_west, last_in_row, output ready);
endinterface

>>> hdl/emr_mod_unit.sv
// ----------------------------------------------------------------------------
// emr_mod_unit
// Restoring remainder unit: 4-bit dividend mod 5-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module emr_mod_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  emr_pkg::emr_mod_req_t req_i,
  output emr_pkg::emr_mod_rsp_t rsp_o
);

  import emr_pkg::*;

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [1:0]      step_q, step_d;
  logic [3:0]      rem_q, rem_d;
  logic [NumW-1:0] dvs_q, dvs_d;
  logic [7:0]      shifted;

  assign shifted = 8'(dvs_q) << step_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = 2'd3;
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      if (8'(rem_q) >= shifted) begin
        rem_d = rem_q - shifted[3:0];
      end
      step_d = step_q - 2'd1;
      if (step_q == 2'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

>>> hdl/emr_core.sv
// ----------------------------------------------------------------------------
// emr_core
// Row sequencer: merge sweep, group south picks, fresh labels, cell output.
// ----------------------------------------------------------------------------
module emr_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  emr_pkg::emr_item_t     in_item_i,
  input  logic [emr_pkg::NumW-1:0] n_cols_i,
  input  logic [emr_pkg::RowW-1:0] rows_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output emr_pkg::emr_word_t     out_word_o
);

  import emr_pkg::*;

  emr_state_e state_q, state_d;

  logic [RowW-1:0]    row_q, row_d;
  logic [3:0]         label_q [MaxCols];
  logic [3:0]         label_d [MaxCols];
  logic [3:0]         choice_q [MaxCols];
  logic [3:0]         choice_d [MaxCols];
  logic [MaxCols-1:0] north_q, north_d;
  logic [MaxCols-1:0] east_q, east_d, west_q, west_d, south_q, south_d;
  logic [MaxCols-1:0] used_q, used_d;
  logic [NumW-1:0]    cnt_q, cnt_d;
  logic [3:0]         cur_q, cur_d;
  logic               last_q, last_d;
  emr_item_t          item_q, item_d;
  logic               ovalid_q, ovalid_d;
  emr_word_t          oword_q, oword_d;

  emr_mod_req_t mod_req;
  emr_mod_rsp_t mod_rsp;

  emr_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  logic [ColW-1:0]    c4;
  logic [3:0]         lab_c, lab_r;
  logic [MaxCols-1:0] eq, below, used_now;
  logic [NumW-1:0]    size, idx;
  logic [3:0]         fresh_lab;
  logic               found;
  logic               south_bit;

  assign c4    = cnt_q[ColW-1:0];
  assign lab_c = label_q[c4];
  assign lab_r = label_q[c4 + ColW'(1)];

  always_comb begin
    for (int k = 0; k < MaxCols; k++) begin
      eq[k]    = (label_q[k] == lab_c) && (NumW'(k) < n_cols_i);
      below[k] = eq[k] && (NumW'(k) < cnt_q);
    end
    size = popcount(eq);
    idx  = popcount(below);
  end

  always_comb begin
    used_now = used_q;
    if (cnt_q == '0) begin
      used_now = '0;
      for (int k = 0; k < MaxCols; k++) begin
        if (south_q[k] && (NumW'(k) < n_cols_i)) begin
          used_now[label_q[k]] = 1'b1;
        end
      end
    end
    found     = 1'b0;
    fresh_lab = '0;
    for (int l = 0; l < MaxCols; l++) begin
      if (!found && !used_now[l]) begin
        found     = 1'b1;
        fresh_lab = 4'(l);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    label_d  = label_q;
    choice_d = choice_q;
    north_d  = north_q;
    east_d   = east_q;
    west_d   = west_q;
    south_d  = south_q;
    used_d   = used_q;
    cnt_d    = cnt_q;
    cur_d    = cur_q;
    last_d   = last_q;
    item_d   = item_q;
    ovalid_d = ovalid_q && !out_ready_i;
    oword_d  = oword_q;
    mod_req  = '{start: 1'b0, dividend: item_q.pick_word[4*c4 +: 4], divisor: size};
    south_bit = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          item_d  = in_item_i;
          last_d  = (17'(row_q) + 17'd1) >= 17'(rows_i);
          east_d  = '0;
          west_d  = '0;
          south_d = '0;
          cnt_d   = '0;
          cur_d   = label_q[0];
          if (row_q == '0) begin
            for (int k = 0; k < MaxCols; k++) begin
              label_d[k] = 4'(k);
            end
            north_d = '0;
            cur_d   = '0;
          end
          state_d = StMerge;
        end
      end
      StMerge: begin
        if ((last_q || item_q.merge_bits[c4]) && (cur_q != lab_r)) begin
          for (int k = 0; k < MaxCols; k++) begin
            if ((label_q[k] == lab_r) && (NumW'(k) < n_cols_i)) begin
              label_d[k] = cur_q;
            end
          end
          east_d[c4]            = 1'b1;
          west_d[c4 + ColW'(1)] = 1'b1;
        end else begin
          cur_d = lab_r;
        end
        if (cnt_q == n_cols_i - NumW'(2)) begin
          cnt_d   = '0;
          state_d = last_q ? StEmit : StGroup;
        end else begin
          cnt_d = cnt_q + NumW'(1);
        end
      end
      StGroup, StWait: begin
        if (state_q == StGroup && below == '0) begin
          mod_req.start = 1'b1;
          state_d       = StWait;
        end else if (state_q == StGroup || mod_rsp.done) begin
          if (state_q == StWait) begin
            choice_d[lab_c] = mod_rsp.rem;
            south_bit       = (mod_rsp.rem == 4'd0);
          end else begin
            south_bit = (idx[3:0] == choice_q[lab_c]);
          end
          south_d[c4] = south_bit || item_q.extra_down_bits[c4];
          if (cnt_q == n_cols_i - NumW'(1)) begin
            cnt_d   = '0;
            state_d = StFresh;
          end else begin
            cnt_d   = cnt_q + NumW'(1);
            state_d = StGroup;
          end
        end
      end
      StFresh: begin
        used_d = used_now;
        if (!(south_q[c4] && (cnt_q < n_cols_i))) begin
          label_d[c4]       = fresh_lab;
          used_d[fresh_lab] = 1'b1;
        end
        if (cnt_q == NumW'(MaxCols - 1)) begin
          cnt_d   = '0;
          state_d = StEmit;
        end else begin
          cnt_d = cnt_q + NumW'(1);
        end
      end
      StEmit: begin
        if (!ovalid_q || out_ready_i) begin
          ovalid_d            = 1'b1;
          oword_d.cell_column = c4;
          oword_d.cell_row    = row_q;
          oword_d.open_north  = north_q[c4];
          oword_d.open_south  = south_q[c4];
          oword_d.open_east   = east_q[c4];
          oword_d.open_west   = west_q[c4];
          oword_d.last_in_row = (cnt_q == n_cols_i - NumW'(1));
          if (cnt_q == n_cols_i - NumW'(1)) begin
            if (last_q) begin
              row_d = '0;
            end else begin
              for (int k = 0; k < MaxCols; k++) begin
                north_d[k] = (NumW'(k) < n_cols_i) ? south_q[k] : 1'b0;
              end
              row_d = row_q + RowW'(1);
            end
            state_d = StIdle;
          end else begin
            cnt_d = cnt_q + NumW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      row_q    <= '0;
      north_q  <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      row_q    <= row_d;
      north_q  <= north_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    label_q  <= label_d;
    choice_q <= choice_d;
    east_q   <= east_d;
    west_q   <= west_d;
    south_q  <= south_d;
    used_q   <= used_d;
    cur_q    <= cur_d;
    last_q   <= last_d;
    item_q   <= item_d;
    oword_q  <= oword_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = ovalid_q;
  assign out_word_o  = oword_q;

endmodule

>>> hdl/eller_maze_row_generator_top.sv
// ----------------------------------------------------------------------------
// eller_maze_row_generator_top
// Eller maze generator, one row per input word, one output word per cell.
// ----------------------------------------------------------------------------
// Ordinary row of n columns: accept, merge sweep, group pass (one remainder per
// set from the shared remainder unit), relabel pass over all columns, then output.
// Last row: accept, merge sweep and output.
// Output cycles stretch while the receiver stalls. One row in flight at a time.
// Reset clears control, row index and north passages; widths 16x16 defaults.
// Set labels need no reset: the first row of every maze writes them.
// ----------------------------------------------------------------------------
module eller_maze_row_generator_top (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_idx_i,
  input  logic [emr_pkg::CfgW-1:0] cfg_data_i,
  emr_in_if.sink                 row_i,
  emr_out_if.source              cell_o
);

  import emr_pkg::*;

  logic [NumW-1:0] cols_q;
  logic [RowW-1:0] rows_q;
  logic [NumW-1:0] n_cols;
  emr_item_t       item;
  emr_word_t       word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= NumW'(MaxCols);
      rows_q <= RowW'(16);
    end else if (cfg_we_i) begin
      unique case (emr_cfg_idx_e'(cfg_idx_i))
        CfgColsInUse: cols_q <= cfg_data_i[NumW-1:0];
        CfgRowsInUse: rows_q <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    n_cols = cols_q;
    if (cols_q < NumW'(2)) begin
      n_cols = NumW'(2);
    end else if (cols_q > NumW'(MaxCols)) begin
      n_cols = NumW'(MaxCols);
    end
  end

  assign item.merge_bits      = row_i.merge_bits;
  assign item.extra_down_bits = row_i.extra_down_bits;
  assign item.pick_word       = row_i.pick_word;

  emr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (row_i.valid),
    .in_ready_o  (row_i.ready),
    .in_item_i   (item),
    .n_cols_i    (n_cols),
    .rows_i      (rows_q),
    .out_valid_o (cell_o.valid),
    .out_ready_i (cell_o.ready),
    .out_word_o  (word)
  );

  assign cell_o.cell_column = word.cell_column;
  assign cell_o.cell_row    = word.cell_row;
  assign cell_o.open_north  = word.open_north;
  assign cell_o.open_south  = word.open_south;
  assign cell_o.open_east   = word.open_east;
  assign cell_o.open_west   = word.open_west;
  assign cell_o.last_in_row = word.last_in_row;

endmodule
